/* sv/cau_pkg.sv */
// ----------------------------------------------------------------------------
// cau_pkg
// Shared codes, constants, result types and rounding helpers for the complex
// arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam logic [2:0] FN_ADD = 3'd0;
  localparam logic [2:0] FN_SUB = 3'd1;
  localparam logic [2:0] FN_MUL = 3'd2;
  localparam logic [2:0] FN_DIV = 3'd3;
  localparam logic [2:0] FN_R2P = 3'd4;
  localparam logic [2:0] FN_P2R = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIVZ = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  localparam int LAT_ALU = 38;
  localparam int CW      = 35;

  localparam logic signed [CW-1:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [CW-1:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [CW-1:0] TWO_PI_Q30  = 35'sd6746518852;

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    logic [1:0]  st;
  } cau_res_t;

  typedef struct packed {
    logic [31:0] v;
    logic        s;
  } cau_sat_t;

  function automatic logic [29:0] atan_q30(input int i);
    logic [29:0] a;
    unique case (i)
      0:  a = 30'h3243F6A8;
      1:  a = 30'h1DAC6705;
      2:  a = 30'h0FADBAFC;
      3:  a = 30'h07F56EA6;
      4:  a = 30'h03FEAB76;
      5:  a = 30'h01FFD55B;
      6:  a = 30'h00FFFAAA;
      7:  a = 30'h007FFF55;
      8:  a = 30'h003FFFEA;
      9:  a = 30'h001FFFFD;
      10: a = 30'h000FFFFF;
      11: a = 30'h0007FFFF;
      12: a = 30'h0003FFFF;
      13: a = 30'h0001FFFF;
      14: a = 30'h0000FFFF;
      15: a = 30'h00007FFF;
      16: a = 30'h00003FFF;
      17: a = 30'h00001FFF;
      18: a = 30'h00000FFF;
      19: a = 30'h000007FF;
      20: a = 30'h000003FF;
      21: a = 30'h000001FF;
      22: a = 30'h000000FF;
      23: a = 30'h0000007F;
      24: a = 30'h0000003F;
      25: a = 30'h0000001F;
      26: a = 30'h0000000F;
      27: a = 30'h00000008;
      28: a = 30'h00000004;
      29: a = 30'h00000002;
      default: a = '0;
    endcase
    return a;
  endfunction

  function automatic logic [29:0] gain_q30(input int n);
    logic [29:0] g;
    unique case (n)
      8:  g = 30'd652039507;
      9:  g = 30'd652034532;
      10: g = 30'd652033289;
      11: g = 30'd652032978;
      12: g = 30'd652032900;
      13: g = 30'd652032881;
      14: g = 30'd652032876;
      default: g = 30'd652032874;
    endcase
    return g;
  endfunction

  // apply sign to a rounded magnitude and clamp to 32 bits
  function automatic cau_sat_t sat32(input logic neg, input logic [64:0] r);
    cau_sat_t o;
    if (neg) begin
      if (r > 65'h0_8000_0000) begin
        o.v = 32'h8000_0000;
        o.s = 1'b1;
      end else begin
        o.v = 32'd0 - r[31:0];
        o.s = 1'b0;
      end
    end else if (r > 65'h0_7FFF_FFFF) begin
      o.v = 32'h7FFF_FFFF;
      o.s = 1'b1;
    end else begin
      o.v = r[31:0];
      o.s = 1'b0;
    end
    return o;
  endfunction

  function automatic cau_sat_t sat_sum(input logic signed [32:0] v);
    cau_sat_t o;
    if (v > 33'sh0_7FFF_FFFF) begin
      o.v = 32'h7FFF_FFFF;
      o.s = 1'b1;
    end else if (v < 33'sh1_8000_0000) begin
      o.v = 32'h8000_0000;
      o.s = 1'b1;
    end else begin
      o.v = v[31:0];
      o.s = 1'b0;
    end
    return o;
  endfunction

endpackage

/* sv/complex_arithmetic_unit.sv */
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Complex add, subtract, multiply, divide and CORDIC polar conversions on
// signed fixed point operands, one word per cycle through a deep pipeline.
//
//   channel  handshake           payload
//   op       op_valid/op_stall   func, a_re, a_im, b_re, b_im
//   res      res_valid/res_stall res_re, res_im, status
//
// One word enters per cycle while res is not stalled; the pipeline depth is set
// by the 34-stage divider or by the phase reduction plus CORDIC stages. rst
// clears the valid bits only.
// A stall on res holds the whole pipeline; op_stall follows res_stall while
// a result waits.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit
  import cau_pkg::*;
#(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               op_valid,
  output logic               op_stall,
  input  logic [2:0]         func,
  input  logic signed [31:0] a_re,
  input  logic signed [31:0] a_im,
  input  logic signed [31:0] b_re,
  input  logic signed [31:0] b_im,
  output logic               res_valid,
  input  logic               res_stall,
  output logic signed [31:0] res_re,
  output logic signed [31:0] res_im,
  output logic [1:0]         status
);

  localparam int LAT_CR = (30 - FRAC_BITS) + CORDIC_STEPS + 6;
  localparam int LAT    = (LAT_CR > LAT_ALU) ? LAT_CR : LAT_ALU;

  logic               en;
  logic               v1;
  logic [2:0]         f1;
  logic signed [31:0] ar1, ai1, br1, bi1;
  logic [LAT-1:0]     vc;
  cau_res_t           alu_r, alu_p, cr_r, cr_p, sel;
  logic [2:0]         fd;

  assign en       = !res_valid || !res_stall;
  assign op_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      vc        <= '0;
      res_valid <= 1'b0;
    end else if (en) begin
      v1        <= op_valid;
      vc        <= {vc[LAT-2:0], v1};
      res_valid <= vc[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1     <= func;
      ar1    <= a_re;
      ai1    <= a_im;
      br1    <= b_re;
      bi1    <= b_im;
      res_re <= sel.re;
      res_im <= sel.im;
      status <= sel.st;
    end
  end

  cau_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
    .clk(clk), .en(en), .func(f1),
    .a_re(ar1), .a_im(ai1), .b_re(br1), .b_im(bi1),
    .res(alu_r)
  );

  cau_cordic #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .en(en), .rot(f1 == FN_P2R),
    .a_re(ar1), .a_im(ai1),
    .res(cr_r)
  );

  cau_delay #(.W($bits(cau_res_t)), .DEPTH(LAT - LAT_ALU)) u_alu_pad (
    .clk(clk), .en(en), .din(alu_r), .dout(alu_p)
  );

  cau_delay #(.W($bits(cau_res_t)), .DEPTH(LAT - LAT_CR)) u_cr_pad (
    .clk(clk), .en(en), .din(cr_r), .dout(cr_p)
  );

  cau_delay #(.W(3), .DEPTH(LAT)) u_func_dly (
    .clk(clk), .en(en), .din(f1), .dout(fd)
  );

  always_comb begin
    unique case (fd)
      FN_ADD, FN_SUB, FN_MUL, FN_DIV: sel = alu_p;
      FN_R2P, FN_P2R:                 sel = cr_p;
      default: begin
        sel.re = '0;
        sel.im = '0;
        sel.st = ST_OK;
      end
    endcase
  end

endmodule

/* sv/cau_delay.sv */
// ----------------------------------------------------------------------------
// cau_delay
// Enabled shift line that aligns a data word to the common pipeline depth.
// ----------------------------------------------------------------------------
module cau_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  generate
    if (DEPTH == 0) begin : g_pass
      assign dout = din;
    end else begin : g_line
      logic [W-1:0] line [DEPTH];
      always_ff @(posedge clk) begin
        if (en) begin
          line[0] <= din;
          for (int i = 1; i < DEPTH; i++) begin
            line[i] <= line[i-1];
          end
        end
      end
      assign dout = line[DEPTH-1];
    end
  endgenerate

endmodule

/* sv/cau_alu.sv */
// ----------------------------------------------------------------------------
// cau_alu
// Add, subtract, multiply and divide lane: product stage, sum stage, magnitude
// stage, a restoring divider of one quotient bit per stage, and a final
// rounding and selection stage.
// ----------------------------------------------------------------------------
module cau_alu
  import cau_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               en,
  input  logic [2:0]         func,
  input  logic signed [31:0] a_re,
  input  logic signed [31:0] a_im,
  input  logic signed [31:0] b_re,
  input  logic signed [31:0] b_im,
  output cau_res_t           res
);

  localparam int QB = 34;
  localparam int RW = (65 + FRAC_BITS > 97) ? 65 + FRAC_BITS : 97;

  typedef struct packed {
    logic [RW-1:0] rr;
    logic [RW-1:0] ri;
    logic [QB-1:0] qr;
    logic [QB-1:0] qi;
    logic [63:0]   den;
    logic          nr;
    logic          ni;
    logic          dz;
  } dstep_t;

  function automatic logic [63:0] mag66(input logic signed [65:0] v);
    logic signed [65:0] t;
    t = v[65] ? -v : v;
    return t[63:0];
  endfunction

  function automatic dstep_t div_step(input dstep_t s, input int k);
    dstep_t        o;
    logic [RW-1:0] dk;
    logic          gr;
    logic          gi;
    o  = s;
    dk = RW'(s.den) << k;
    gr = s.rr >= dk;
    gi = s.ri >= dk;
    if (gr) o.rr = s.rr - dk;
    if (gi) o.ri = s.ri - dk;
    o.qr = {s.qr[QB-2:0], gr};
    o.qi = {s.qi[QB-2:0], gi};
    return o;
  endfunction

  logic signed [63:0] p_rr, p_ii, p_ri, p_ir, p_bbr, p_bbi;
  cau_res_t           as_res, as_next;
  logic signed [65:0] m_re, m_im, n_re, n_im;
  logic [63:0]        den_q;
  logic [63:0]        mm_re, mm_im, nm_re, nm_im, den_r;
  logic               mn_re, mn_im, nn_re, nn_im, dz_r;
  cau_res_t           mul_res, mul_next;
  dstep_t             ds_in;
  dstep_t             ds [QB];
  cau_res_t           as_d, mul_d, res_next;
  logic [2:0]         op_d;

  always_comb begin
    logic signed [32:0] s_re;
    logic signed [32:0] s_im;
    cau_sat_t           o_re;
    cau_sat_t           o_im;
    if (func == FN_SUB) begin
      s_re = 33'(a_re) - 33'(b_re);
      s_im = 33'(a_im) - 33'(b_im);
    end else begin
      s_re = 33'(a_re) + 33'(b_re);
      s_im = 33'(a_im) + 33'(b_im);
    end
    o_re = sat_sum(s_re);
    o_im = sat_sum(s_im);
    as_next.re = o_re.v;
    as_next.im = o_im.v;
    as_next.st = (o_re.s || o_im.s) ? ST_SAT : ST_OK;
  end

  always_comb begin
    logic [64:0] r_re;
    logic [64:0] r_im;
    cau_sat_t    o_re;
    cau_sat_t    o_im;
    r_re = 65'(mm_re >> FRAC_BITS) + 65'(mm_re[FRAC_BITS-1]);
    r_im = 65'(mm_im >> FRAC_BITS) + 65'(mm_im[FRAC_BITS-1]);
    o_re = sat32(mn_re, r_re);
    o_im = sat32(mn_im, r_im);
    mul_next.re = o_re.v;
    mul_next.im = o_im.v;
    mul_next.st = (o_re.s || o_im.s) ? ST_SAT : ST_OK;
  end

  always_comb begin
    ds_in.rr  = RW'(nm_re) << (FRAC_BITS + 1);
    ds_in.ri  = RW'(nm_im) << (FRAC_BITS + 1);
    ds_in.qr  = '0;
    ds_in.qi  = '0;
    ds_in.den = den_r;
    ds_in.nr  = nn_re;
    ds_in.ni  = nn_im;
    ds_in.dz  = dz_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_rr    <= a_re * b_re;
      p_ii    <= a_im * b_im;
      p_ri    <= a_re * b_im;
      p_ir    <= a_im * b_re;
      p_bbr   <= b_re * b_re;
      p_bbi   <= b_im * b_im;
      as_res  <= as_next;
      m_re    <= 66'(p_rr) - 66'(p_ii);
      m_im    <= 66'(p_ri) + 66'(p_ir);
      n_re    <= 66'(p_rr) + 66'(p_ii);
      n_im    <= 66'(p_ir) - 66'(p_ri);
      den_q   <= 64'(p_bbr) + 64'(p_bbi);
      mm_re   <= mag66(m_re);
      mm_im   <= mag66(m_im);
      nm_re   <= mag66(n_re);
      nm_im   <= mag66(n_im);
      mn_re   <= m_re[65];
      mn_im   <= m_im[65];
      nn_re   <= n_re[65];
      nn_im   <= n_im[65];
      den_r   <= den_q;
      dz_r    <= den_q == 64'd0;
      mul_res <= mul_next;
      ds[0]   <= div_step(ds_in, QB - 1);
      for (int i = 1; i < QB; i++) begin
        ds[i] <= div_step(ds[i-1], QB - 1 - i);
      end
      res <= res_next;
    end
  end

  cau_delay #(.W($bits(cau_res_t)), .DEPTH(LAT_ALU - 2)) u_as_dly (
    .clk(clk), .en(en), .din(as_res), .dout(as_d)
  );

  cau_delay #(.W($bits(cau_res_t)), .DEPTH(LAT_ALU - 5)) u_mul_dly (
    .clk(clk), .en(en), .din(mul_res), .dout(mul_d)
  );

  cau_delay #(.W(3), .DEPTH(LAT_ALU - 1)) u_op_dly (
    .clk(clk), .en(en), .din(func), .dout(op_d)
  );

  always_comb begin
    dstep_t      f;
    logic [32:0] qq_re;
    logic [32:0] qq_im;
    cau_sat_t    o_re;
    cau_sat_t    o_im;
    cau_res_t    dv;
    f     = ds[QB-1];
    qq_re = f.qr[QB-2:0];
    qq_im = f.qi[QB-2:0];
    o_re  = sat32(f.nr, 65'(qq_re >> 1) + 65'(qq_re[0]));
    o_im  = sat32(f.ni, 65'(qq_im >> 1) + 65'(qq_im[0]));
    if (f.qr[QB-1]) begin
      o_re.v = f.nr ? 32'h8000_0000 : 32'h7FFF_FFFF;
      o_re.s = 1'b1;
    end
    if (f.qi[QB-1]) begin
      o_im.v = f.ni ? 32'h8000_0000 : 32'h7FFF_FFFF;
      o_im.s = 1'b1;
    end
    if (f.dz) begin
      dv.re = '0;
      dv.im = '0;
      dv.st = ST_DIVZ;
    end else begin
      dv.re = o_re.v;
      dv.im = o_im.v;
      dv.st = (o_re.s || o_im.s) ? ST_SAT : ST_OK;
    end
    unique case (op_d)
      FN_ADD, FN_SUB: res_next = as_d;
      FN_MUL:         res_next = mul_d;
      default:        res_next = dv;
    endcase
  end

endmodule

/* sv/cau_cordic.sv */
// ----------------------------------------------------------------------------
// cau_cordic
// Polar conversion lane: phase reduction by one compare-subtract per stage,
// quadrant fold, one CORDIC micro-rotation per stage, gain and magnitude
// multiply, rounding and clamping.
// ----------------------------------------------------------------------------
module cau_cordic
  import cau_pkg::*;
#(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               en,
  input  logic               rot,
  input  logic signed [31:0] a_re,
  input  logic signed [31:0] a_im,
  output cau_res_t           res
);

  localparam int S   = 30 - FRAC_BITS;
  localparam int TMW = 62 - FRAC_BITS;
  localparam int N   = CORDIC_STEPS;
  localparam logic [29:0] GAIN = gain_q30(CORDIC_STEPS);
  localparam logic signed [31:0] PIF =
    32'((PI_Q30 + (35'sd1 <<< (29 - FRAC_BITS))) >>> S);

  typedef struct packed {
    logic                   rot;
    logic                   zero;
    logic signed [31:0]     r;
    logic [TMW-1:0]         tm;
    logic                   tn;
    logic signed [CW-1:0]   x;
    logic signed [CW-1:0]   y;
    logic signed [CW-1:0]   z;
  } prep_t;

  typedef struct packed {
    logic                   rot;
    logic                   zero;
    logic                   flip;
    logic signed [31:0]     r;
    logic signed [CW-1:0]   x;
    logic signed [CW-1:0]   y;
    logic signed [CW-1:0]   z;
  } cs_t;

  function automatic prep_t mod_step(input prep_t s, input int k);
    prep_t          o;
    logic [TMW-1:0] c;
    o = s;
    c = TMW'(TWO_PI_Q30) << k;
    if (s.tm >= c) o.tm = s.tm - c;
    return o;
  endfunction

  function automatic cs_t rot_step(input cs_t s, input int i);
    cs_t                  o;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] at;
    logic                 pos;
    o   = s;
    dx  = s.y >>> i;
    dy  = s.x >>> i;
    at  = CW'(atan_q30(i));
    pos = s.rot ? !s.z[CW-1] : s.y[CW-1];
    if (pos) begin
      o.x = s.x - dx;
      o.y = s.y + dy;
      o.z = s.z - at;
    end else begin
      o.x = s.x + dx;
      o.y = s.y - dy;
      o.z = s.z + at;
    end
    return o;
  endfunction

  function automatic logic [64:0] round30(input logic signed [2*CW-1:0] p);
    logic signed [2*CW-1:0] m;
    m = p[2*CW-1] ? -p : p;
    return 65'(m >> 30) + 65'(m[29]);
  endfunction

  prep_t                  pa_next;
  prep_t                  pp [S+1];
  cs_t                    w_next, wr, h_next, pst_next, pst;
  cs_t                    cs [N+1];
  logic signed [2*CW-1:0] pr_re, pr_im;
  logic signed [CW-1:0]   mz;
  logic                   mrot, mzero;
  cau_res_t               res_next;

  always_comb begin
    logic signed [TMW:0]   tw;
    logic signed [CW-1:0]  ex;
    logic signed [CW-1:0]  ey;
    tw = (TMW+1)'(a_im) <<< S;
    ex = CW'(a_re);
    ey = CW'(a_im);
    pa_next.rot  = rot;
    pa_next.zero = (a_re == 32'sd0) && (a_im == 32'sd0);
    pa_next.r    = a_re;
    pa_next.tn   = tw[TMW];
    pa_next.tm   = tw[TMW] ? TMW'(-tw) : TMW'(tw);
    if (a_re[31]) begin
      pa_next.x = -ex;
      pa_next.y = -ey;
      pa_next.z = a_im[31] ? -PI_Q30 : PI_Q30;
    end else begin
      pa_next.x = ex;
      pa_next.y = ey;
      pa_next.z = '0;
    end
  end

  always_comb begin
    prep_t                p;
    logic signed [CW-1:0] tp;
    p  = pp[S];
    tp = CW'(p.tm);
    w_next.rot  = p.rot;
    w_next.zero = p.zero;
    w_next.flip = 1'b0;
    w_next.r    = p.r;
    w_next.x    = p.x;
    w_next.y    = p.y;
    if (!p.rot) begin
      w_next.z = p.z;
    end else if (!p.tn) begin
      w_next.z = (tp > PI_Q30) ? tp - TWO_PI_Q30 : tp;
    end else begin
      w_next.z = (tp > PI_Q30) ? TWO_PI_Q30 - tp : -tp;
    end
  end

  always_comb begin
    h_next = wr;
    if (wr.rot) begin
      h_next.x = CW'(GAIN);
      h_next.y = '0;
      if (wr.z > HALF_PI_Q30) begin
        h_next.z    = wr.z - PI_Q30;
        h_next.flip = 1'b1;
      end else if (wr.z < -HALF_PI_Q30) begin
        h_next.z    = wr.z + PI_Q30;
        h_next.flip = 1'b1;
      end
    end
  end

  always_comb begin
    pst_next = cs[N];
    if (cs[N].flip) begin
      pst_next.x = -cs[N].x;
      pst_next.y = -cs[N].y;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [CW-1:0] opa;
    logic signed [CW-1:0] opb;
    logic signed [CW-1:0] opr;
    if (en) begin
      pp[0] <= pa_next;
      for (int j = 1; j <= S; j++) begin
        pp[j] <= mod_step(pp[j-1], S - j);
      end
      wr    <= w_next;
      cs[0] <= h_next;
      for (int i = 1; i <= N; i++) begin
        cs[i] <= rot_step(cs[i-1], i - 1);
      end
      pst   <= pst_next;
      opr   = CW'(pst.r);
      opa   = pst.rot ? opr : pst.x;
      opb   = pst.rot ? pst.x : CW'(GAIN);
      pr_re <= opa * opb;
      pr_im <= opr * pst.y;
      mz    <= pst.z;
      mrot  <= pst.rot;
      mzero <= pst.zero;
      res   <= res_next;
    end
  end

  always_comb begin
    cau_sat_t             o_re;
    cau_sat_t             o_im;
    cau_sat_t             o_ph;
    logic signed [CW-1:0] zm;
    logic signed [31:0]   ph;
    o_re = sat32(pr_re[2*CW-1], round30(pr_re));
    o_im = sat32(pr_im[2*CW-1], round30(pr_im));
    zm   = mz[CW-1] ? -mz : mz;
    o_ph = sat32(mz[CW-1], 65'(zm >>> S) + 65'(zm[S-1]));
    ph   = o_ph.v;
    if (ph > PIF) ph = PIF;
    if (ph < -PIF) ph = -PIF;
    if (mrot) begin
      res_next.re = o_re.v;
      res_next.im = o_im.v;
      res_next.st = (o_re.s || o_im.s) ? ST_SAT : ST_OK;
    end else if (mzero) begin
      res_next.re = '0;
      res_next.im = '0;
      res_next.st = ST_OK;
    end else begin
      res_next.re = o_re.v;
      res_next.im = ph;
      res_next.st = o_re.s ? ST_SAT : ST_OK;
    end
  end

endmodule

/* tb/complex_arithmetic_unit_tb.sv */
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_tb
// Self-checking bench for the complex arithmetic unit. Directed corner words
// (saturation, zero denominator, polar origin and phase wrap, unused selectors)
// are followed by random words under three idling mixes. A scoreboard predicts
// every result and compares it with the block's output in order.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_tb;
  import cau_pkg::*;

  localparam int FRAC      = 16;
  localparam int STEPS     = 16;
  localparam int N_RANDOM  = 1500;
  localparam int WD_LIMIT  = 20000;
  localparam longint GAIN  = 64'd652032874;
  localparam longint PI_F  = 64'sd3373259426;
  localparam longint HPI_F = 64'sd1686629713;
  localparam longint TPI_F = 64'sd6746518852;
  localparam longint ATAN_TAB [0:15] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
    64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
    64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
    64'h00007FFF};

  typedef struct {
    logic [2:0]         fn;
    logic signed [31:0] ar, ai, br, bi;
  } op_word_t;

  typedef struct {
    logic signed [31:0] re, im;
    logic [1:0]         st;
  } res_word_t;

  class cau_scoreboard;
    res_word_t expected_q[$];
    int        errors;
    int        checked;
    int        per_fn[8];

    function logic signed [31:0] round_clamp(bit neg, logic [63:0] mag, int s,
                                             inout logic [1:0] st);
      logic [63:0] r;
      r = mag;
      if (s > 0) r = (mag >> s) + ((mag >> (s - 1)) & 64'd1);
      if (neg) begin
        if (r > 64'h8000_0000) begin
          st = ST_SAT;
          return 32'h8000_0000;
        end
        return 32'(64'd0 - r);
      end
      if (r > 64'h7FFF_FFFF) begin
        st = ST_SAT;
        return 32'h7FFF_FFFF;
      end
      return r[31:0];
    endfunction

    function logic signed [31:0] clamp_sum(longint v, inout logic [1:0] st);
      if (v > 64'sh7FFF_FFFF) begin
        st = ST_SAT;
        return 32'h7FFF_FFFF;
      end
      if (v < -64'sh8000_0000) begin
        st = ST_SAT;
        return 32'h8000_0000;
      end
      return v[31:0];
    endfunction

    function logic signed [31:0] round_prod(longint p, int s, inout logic [1:0] st);
      logic [63:0] mag;
      mag = (p < 0) ? 64'd0 - p : p;
      return round_clamp(p < 0, mag, s, st);
    endfunction

    function void merge_prods(longint p, longint q, output bit neg,
                              output logic [63:0] mag);
      logic [63:0] s;
      s = p + q;
      if (s == 64'h8000_0000_0000_0000 || !s[63]) begin
        neg = 0;
        mag = s;
      end else begin
        neg = 1;
        mag = 64'd0 - s;
      end
    endfunction

    function logic signed [31:0] quotient(bit neg, logic [63:0] mag, logic [63:0] den,
                                          inout logic [1:0] st);
      logic [63:0] q, r;
      q = mag / den;
      r = mag % den;
      if (q >= (64'd1 << (32 - FRAC))) begin
        st = ST_SAT;
        return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      for (int k = 0; k <= FRAC; k++) begin
        r = r << 1;
        q = q << 1;
        if (r >= den) begin
          r = r - den;
          q = q | 64'd1;
        end
      end
      return round_clamp(neg, q, 1, st);
    endfunction

    function res_word_t predict(op_word_t w);
      res_word_t   o;
      longint      ar, ai, br, bi, x, y, z, t, dx, dy, pif;
      logic [63:0] mag, den, ux;
      logic [1:0]  dummy;
      bit          neg, flip;
      ar = w.ar; ai = w.ai; br = w.br; bi = w.bi;
      o.re = 0; o.im = 0; o.st = ST_OK; dummy = ST_OK;
      case (w.fn)
        FN_ADD: begin
          o.re = clamp_sum(ar + br, o.st);
          o.im = clamp_sum(ai + bi, o.st);
        end
        FN_SUB: begin
          o.re = clamp_sum(ar - br, o.st);
          o.im = clamp_sum(ai - bi, o.st);
        end
        FN_MUL: begin
          merge_prods(ar * br, -(ai * bi), neg, mag);
          o.re = round_clamp(neg, mag, FRAC, o.st);
          merge_prods(ar * bi, ai * br, neg, mag);
          o.im = round_clamp(neg, mag, FRAC, o.st);
        end
        FN_DIV: begin
          den = br * br + bi * bi;
          if (den == 0) o.st = ST_DIVZ;
          else begin
            merge_prods(ar * br, ai * bi, neg, mag);
            o.re = quotient(neg, mag, den, o.st);
            merge_prods(ai * br, -(ar * bi), neg, mag);
            o.im = quotient(neg, mag, den, o.st);
          end
        end
        FN_R2P: begin
          if (ar != 0 || ai != 0) begin
            x = ar; y = ai; z = 0;
            if (x < 0) begin
              z = (y >= 0) ? PI_F : -PI_F;
              x = -x;
              y = -y;
            end
            for (int i = 0; i < STEPS; i++) begin
              dx = y >>> i;
              dy = x >>> i;
              if (y >= 0) begin
                x += dx; y -= dy; z += ATAN_TAB[i];
              end else begin
                x -= dx; y += dy; z -= ATAN_TAB[i];
              end
            end
            ux = x;
            o.re = round_clamp(0, ux * GAIN, 30, o.st);
            o.im = round_prod(z, 30 - FRAC, dummy);
            pif = (PI_F + (64'sd1 << (29 - FRAC))) >>> (30 - FRAC);
            if (longint'(o.im) > pif) o.im = pif[31:0];
            if (longint'(o.im) < -pif) o.im = 32'(-pif);
          end
        end
        FN_P2R: begin
          t = ai * (64'sd1 <<< (30 - FRAC));
          x = GAIN; y = 0; flip = 0;
          t = t % TPI_F;
          if (t > PI_F) t -= TPI_F;
          else if (t < -PI_F) t += TPI_F;
          if (t > HPI_F) begin
            t -= PI_F; flip = 1;
          end else if (t < -HPI_F) begin
            t += PI_F; flip = 1;
          end
          for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (t >= 0) begin
              x -= dx; y += dy; t -= ATAN_TAB[i];
            end else begin
              x += dx; y -= dy; t += ATAN_TAB[i];
            end
          end
          if (flip) begin
            x = -x; y = -y;
          end
          o.re = round_prod(ar * x, 30, o.st);
          o.im = round_prod(ar * y, 30, o.st);
        end
        default: ;
      endcase
      return o;
    endfunction

    function void note_op(op_word_t w);
      per_fn[w.fn]++;
      expected_q.push_back(predict(w));
    endfunction

    function void check_res(res_word_t r);
      res_word_t e;
      checked++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result re=%h im=%h st=%0d", $time, r.re, r.im, r.st);
        return;
      end
      e = expected_q.pop_front();
      if (r.re !== e.re) begin
        errors++;
        $display("%0t: res_re expected %h actual %h", $time, e.re, r.re);
      end
      if (r.im !== e.im) begin
        errors++;
        $display("%0t: res_im expected %h actual %h", $time, e.im, r.im);
      end
      if (r.st !== e.st) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, e.st, r.st);
      end
    endfunction
  endclass

  logic               clk = 0;
  logic               rst = 1;
  logic               op_valid = 0;
  logic               op_stall;
  logic [2:0]         func = '0;
  logic signed [31:0] a_re = '0, a_im = '0, b_re = '0, b_im = '0;
  logic               res_valid;
  logic               res_stall = 0;
  logic signed [31:0] res_re, res_im;
  logic [1:0]         status;

  cau_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  complex_arithmetic_unit i_dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(negedge clk) res_stall <= ($urandom_range(99) < recv_stall_pct);

  always @(posedge clk) begin
    op_word_t  w;
    res_word_t r;
    if (!rst) begin
      quiet_cycles++;
      if (op_valid && !op_stall) begin
        w.fn = func; w.ar = a_re; w.ai = a_im; w.br = b_re; w.bi = b_im;
        sb.note_op(w);
        quiet_cycles = 0;
      end
      if (res_valid && !res_stall) begin
        r.re = res_re; r.im = res_im; r.st = status;
        sb.check_res(r);
        quiet_cycles = 0;
      end
      if (quiet_cycles >= WD_LIMIT) begin
        $display("%0t: watchdog expired with %0d results pending", $time,
                 sb.expected_q.size());
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  task automatic send_word(op_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      op_valid <= 0;
      @(negedge clk);
    end
    op_valid <= 1;
    func <= w.fn; a_re <= w.ar; a_im <= w.ai; b_re <= w.br; b_im <= w.bi;
    do @(posedge clk); while (op_stall);
    @(negedge clk);
  endtask

  task automatic send(logic [2:0] fn, logic [31:0] ar, logic [31:0] ai,
                      logic [31:0] br, logic [31:0] bi);
    op_word_t w;
    w.fn = fn; w.ar = ar; w.ai = ai; w.br = br; w.bi = bi;
    send_word(w);
  endtask

  task automatic drain();
    op_valid <= 0;
    while (sb.expected_q.size() != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(4))
      0: return $urandom;
      1: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      2: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
      3: case ($urandom_range(4))
           0: return 32'h8000_0000;
           1: return 32'h7FFF_FFFF;
           2: return 32'hFFFF_FFFF;
           3: return 32'h0000_0001;
           default: return 32'h0;
         endcase
      default: return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
    endcase
  endfunction

  initial begin
    op_word_t w;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    send(FN_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send(FN_ADD, 32'h0001_8000, 32'hFFFF_0000, 32'h0000_8000, 32'h0001_0000);
    send(FN_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send(FN_SUB, 32'h0003_0000, 32'h0, 32'h0001_0000, 32'h0002_0000);
    send(FN_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send(FN_MUL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send(FN_MUL, 32'h0000_8000, 32'h0000_0001, 32'hFFFF_8000, 32'h0000_8000);
    send(FN_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0);
    send(FN_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0);
    send(FN_DIV, 32'h0003_0000, 32'hFFFF_0000, 32'h0001_0000, 32'h0002_0000);
    send(FN_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send(FN_R2P, 32'h0, 32'h0, 32'h1234_5678, 32'h0);
    send(FN_R2P, 32'hFFFF_0000, 32'h0, 32'h0, 32'h0);
    send(FN_R2P, 32'hFFFF_0000, 32'hFFFF_FFFF, 32'h0, 32'h0);
    send(FN_R2P, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0);
    send(FN_R2P, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
    send(FN_P2R, 32'h0001_0000, 32'h0003_243F, 32'h0, 32'h0);
    send(FN_P2R, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0);
    send(FN_P2R, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
    send(FN_P2R, 32'h0002_0000, 32'hFFFE_0000, 32'h0, 32'h0);
    send(3'd6, 32'h1111_1111, 32'h2222_2222, 32'h3333_3333, 32'h4444_4444);
    send(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct  = (phase == 0) ? 24 : (phase == 1) ? 63 : 0;
      recv_stall_pct = (phase == 0) ? 63 : (phase == 1) ? 24 : 0;
      for (int n = 0; n < N_RANDOM / 3; n++) begin
        w.fn = ($urandom_range(19) == 0) ? 3'($urandom_range(6, 7))
                                         : 3'($urandom_range(0, 5));
        w.ar = pick_value(); w.ai = pick_value();
        w.br = pick_value(); w.bi = pick_value();
        if (w.fn == FN_DIV && $urandom_range(9) == 0) begin
          w.br = 0; w.bi = 0;
        end
        send_word(w);
      end
      drain();
    end

    recv_stall_pct = 0;
    repeat (LAT_ALU + 20) @(posedge clk);
    $display("Checked %0d results: add %0d sub %0d mul %0d div %0d", sb.checked,
             sb.per_fn[0], sb.per_fn[1], sb.per_fn[2], sb.per_fn[3]);
    $display("  rect-polar %0d polar-rect %0d unused %0d, three idle mixes",
             sb.per_fn[4], sb.per_fn[5], sb.per_fn[6] + sb.per_fn[7]);
    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
